### rtl/core/kmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants
// Item payloads, the cell-to-cell link and fixed field widths of the
// k-transaction profit chain.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 31;
  localparam int HOLD_W   = 33;
  localparam int CALC_W   = 34;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0]    CFG_RESET  = 5'd2;
  localparam logic [PROFIT_W-1:0] PROFIT_TOP = 31'h7FFF_FFFF;
  // -2^32: nothing bought yet
  localparam logic signed [HOLD_W-1:0] HOLD_NONE = {1'b1, 32'h0000_0000};

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
  } kmp_in_t;

  typedef struct packed {
    logic [PROFIT_W-1:0] profit;
    logic                last_res;
  } kmp_out_t;

  typedef logic [CFG_W-1:0] kmp_cfg_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic                valid;
    logic [PRICE_W-1:0]  price;
    logic                last;
    logic [PROFIT_W-1:0] sold;
    logic [PROFIT_W-1:0] result;
  } kmp_link_t;

endpackage

### rtl/core/kmp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_stream_if: valid/ready channel
// Carries one payload per accepted item.
// ----------------------------------------------------------------------------
interface kmp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/kmp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_cell: one transaction-count cell
// Holds best hold/sold profit for one count, updates it with the passing
// price and hands the new sold value to the next cell.
// ----------------------------------------------------------------------------
module kmp_cell #(
  parameter int CELL_IDX = 0,
  parameter int KW       = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [KW-1:0]     k_i,
  input  kmp_pkg::kmp_link_t link_i,
  output kmp_pkg::kmp_link_t link_o
);
  import kmp_pkg::*;

  logic signed [HOLD_W-1:0] hold_q, hold_d;
  logic [PROFIT_W-1:0]      sold_q, sold_d;
  kmp_link_t                link_q;

  logic signed [CALC_W-1:0] price_x, buy_cand, hold_new, sell_cand;
  logic [PROFIT_W-1:0]      sell_sat, sold_new;

  always_comb begin
    price_x  = $signed({{(CALC_W-PRICE_W){1'b0}}, link_i.price});
    buy_cand = $signed({{(CALC_W-PROFIT_W){1'b0}}, link_i.sold}) - price_x;
    hold_new = ($signed({hold_q[HOLD_W-1], hold_q}) > buy_cand) ?
               $signed({hold_q[HOLD_W-1], hold_q}) : buy_cand;
    sell_cand = hold_new + price_x;
    // clamp to the profit range; negative means no sale yet
    if (sell_cand > $signed({{(CALC_W-PROFIT_W){1'b0}}, PROFIT_TOP})) begin
      sell_sat = PROFIT_TOP;
    end else if (sell_cand < 0) begin
      sell_sat = '0;
    end else begin
      sell_sat = sell_cand[PROFIT_W-1:0];
    end
    sold_new = (sell_sat > sold_q) ? sell_sat : sold_q;

    hold_d = hold_q;
    sold_d = sold_q;
    if (en_i && link_i.valid) begin
      if (link_i.last) begin
        hold_d = HOLD_NONE;
        sold_d = '0;
      end else begin
        hold_d = hold_new[HOLD_W-1:0];
        sold_d = sold_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_NONE;
      sold_q <= '0;
      link_q <= '0;
    end else begin
      hold_q <= hold_d;
      sold_q <= sold_d;
      if (en_i) begin
        link_q.valid  <= link_i.valid;
        link_q.price  <= link_i.price;
        link_q.last   <= link_i.last;
        link_q.sold   <= sold_new;
        // pick up the answer at the selected count
        link_q.result <= (k_i == KW'(CELL_IDX + 1)) ? sold_new : link_i.result;
      end
    end
  end

  assign link_o = link_q;

endmodule

### rtl/core/k_transaction_max_profit_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_transaction_max_profit_dp: best stock profit with at most k transactions
// Systolic chain of MAX_CELLS cells; price items flow one cell per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | payload               | notes
//  in_i    | in  | price[15:0], last     | one price item
//  out_o   | out | profit[30:0], last_res| one result per price
//  cfg_i   | in  | max_transactions[4:0] | always ready, write when idle
//
//  One item per cycle enters and leaves while out_o is not stalled.
//  Cell c updates count c+1 from the registered link of cell c-1, so it
//  always sees the new sold value of the lower count for the same price.
//  A stall on out_o freezes the whole chain and drops in_i.ready.
//  Reset clears all cells to "nothing bought" and sets k to 2; no clearing
//  pass. After an item with last set, each cell returns to reset as it passes.
// ----------------------------------------------------------------------------
module k_transaction_max_profit_dp #(
  parameter int MAX_CELLS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kmp_stream_if.sink   in_i,
  kmp_stream_if.source out_o,
  kmp_stream_if.sink   cfg_i
);
  import kmp_pkg::*;

  localparam int KW = $clog2(MAX_CELLS + 1);

  logic [CFG_W-1:0] max_tx_q;
  logic [KW-1:0]    k_eff;
  logic             chain_en;
  kmp_link_t        links [MAX_CELLS+1];

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tx_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      max_tx_q <= cfg_i.payload;
    end
  end

  // counts above the chain length act as the last cell
  assign k_eff = (32'(max_tx_q) > MAX_CELLS) ? KW'(MAX_CELLS) : KW'(max_tx_q);

  // advance unless the finished item at the end is stalled
  assign chain_en = !links[MAX_CELLS].valid || out_o.ready;
  assign in_i.ready = chain_en;

  always_comb begin
    links[0].valid  = in_i.valid;
    links[0].price  = in_i.payload.price;
    links[0].last   = in_i.payload.last;
    links[0].sold   = '0;
    links[0].result = '0;
  end

  for (genvar c = 0; c < MAX_CELLS; c++) begin : g_cell
    kmp_cell #(
      .CELL_IDX (c),
      .KW       (KW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .k_i    (k_eff),
      .link_i (links[c]),
      .link_o (links[c+1])
    );
  end

  assign out_o.valid            = links[MAX_CELLS].valid;
  assign out_o.payload.profit   = links[MAX_CELLS].result;
  assign out_o.payload.last_res = links[MAX_CELLS].last;

endmodule

### dv/k_transaction_max_profit_dp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_transaction_max_profit_dp_tb: self-checking bench for the k-transaction
// profit chain
// Price sequences are fed through random source and sink stalls. A cycle-free
// model of the buy/sell cells predicts each result, and the results are
// compared in order. The transaction limit k is changed between phases,
// inside open sequences too, and covers 0, the cell count and values above it.
// ----------------------------------------------------------------------------
module k_transaction_max_profit_dp_tb;
  import kmp_pkg::*;

  localparam int CELLS      = 16;
  localparam int RAND_ITEMS = 1152;
  localparam int PHASES     = 12;

  typedef enum int {STYLE_UNIFORM, STYLE_SWING, STYLE_WALK} price_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  kmp_stream_if #(.payload_t(kmp_in_t))  in_if ();
  kmp_stream_if #(.payload_t(kmp_out_t)) out_if ();
  kmp_stream_if #(.payload_t(kmp_cfg_t)) cfg_if ();

  k_transaction_max_profit_dp #(.MAX_CELLS(CELLS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Cell state of the profit model
  logic signed [HOLD_W-1:0] hold_best [CELLS];
  logic [PROFIT_W-1:0]      sold_best [CELLS];
  kmp_cfg_t                 k_now;

  kmp_in_t      price_q [$];
  kmp_out_t     profit_q [$];
  kmp_out_t     want;
  int           src_idle_pct;
  int           snk_idle_pct;
  int           n_queued;
  int           n_accepted;
  int           n_results;
  int           n_mismatch;
  int           n_seq_ends;
  int           seq_left;
  int           walk_price;
  price_style_e seq_style;
  logic [31:0]  k_seen;

  function automatic void clear_cells();
    for (int c = 0; c < CELLS; c++) begin
      hold_best[c] = HOLD_NONE;
      sold_best[c] = '0;
    end
  endfunction

  // Run one price through every cell in count order, return the result for k
  function automatic kmp_out_t next_profit(kmp_in_t it);
    logic signed [CALC_W-1:0] px;
    logic signed [CALC_W-1:0] below;
    logic signed [CALC_W-1:0] cand;
    logic signed [CALC_W-1:0] top;
    kmp_out_t                 r;
    int                       k;
    px    = $signed({{(CALC_W-PRICE_W){1'b0}}, it.price});
    top   = $signed({{(CALC_W-PROFIT_W){1'b0}}, PROFIT_TOP});
    below = '0;
    for (int c = 0; c < CELLS; c++) begin
      cand = below - px;
      if (cand > hold_best[c]) hold_best[c] = cand[HOLD_W-1:0];
      cand = hold_best[c] + px;
      if (cand > top) cand = top;
      if (cand > $signed({1'b0, sold_best[c]})) sold_best[c] = cand[PROFIT_W-1:0];
      below = $signed({{(CALC_W-PROFIT_W){1'b0}}, sold_best[c]});
    end
    k = (k_now > CELLS) ? CELLS : int'(k_now);
    r.profit   = (k == 0) ? '0 : sold_best[k-1];
    r.last_res = it.last;
    if (it.last) clear_cells();
    return r;
  endfunction

  // Next price of the current sequence; start a new sequence when one ends
  function automatic kmp_in_t make_item();
    kmp_in_t it;
    if (seq_left == 0) begin
      seq_left  = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
      seq_style = price_style_e'($urandom_range(2));
      walk_price = $urandom_range(65535);
    end
    if ($urandom_range(9) == 0) begin
      it.price = 16'($urandom_range(65535));
    end else begin
      case (seq_style)
        STYLE_SWING: begin
          it.price = (seq_left % 2) ? 16'($urandom_range(65535, 60000))
                                    : 16'($urandom_range(5000));
        end
        STYLE_WALK: begin
          walk_price = walk_price + int'($urandom_range(4000)) - 2000;
          if (walk_price < 0) walk_price = 0;
          if (walk_price > 65535) walk_price = 65535;
          it.price = 16'(walk_price);
        end
        default: begin
          it.price = 16'($urandom_range(65535));
        end
      endcase
    end
    seq_left--;
    it.last = (seq_left == 0);
    return it;
  endfunction

  function automatic void note_mismatch(string what, longint exp_v, longint act_v);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endfunction

  task automatic push_item(logic [PRICE_W-1:0] price, logic last);
    kmp_in_t it;
    it.price = price;
    it.last  = last;
    price_q.push_back(it);
    n_queued++;
    if (last) n_seq_ends++;
  endtask

  // Hold until every queued item is accepted and every result is back
  task automatic drain();
    while (n_queued != n_accepted || profit_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_k(kmp_cfg_t value);
    @(posedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    k_now         = value;
    k_seen[value] = 1'b1;
    cfg_if.valid <= 1'b0;
  endtask

  // Source side: keep an item on the channel until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        profit_q.push_back(next_profit(in_if.payload));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (price_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= price_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (profit_q.size() == 0) begin
          note_mismatch("result with nothing pending, profit", -1, out_if.payload.profit);
        end else begin
          want = profit_q.pop_front();
          if (out_if.payload.profit !== want.profit) begin
            note_mismatch("profit", want.profit, out_if.payload.profit);
          end
          if (out_if.payload.last_res !== want.last_res) begin
            note_mismatch("last_res", want.last_res, out_if.payload.last_res);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    kmp_cfg_t k_fixed [6];
    kmp_cfg_t k_next;
    rst_ni         <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    clear_cells();
    k_now        = CFG_RESET;
    k_seen       = '0;
    k_seen[CFG_RESET] = 1'b1;
    n_queued     = 0;
    n_accepted   = 0;
    n_results    = 0;
    n_mismatch   = 0;
    n_seq_ends   = 0;
    seq_left     = 0;
    walk_price   = 0;
    seq_style    = STYLE_UNIFORM;
    src_idle_pct = 25;
    snk_idle_pct = 25;
    k_fixed      = '{5'd1, 5'd17, 5'd0, 5'd16, 5'd31, 5'd3};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of k first, with full-scale swings
    push_item(16'd40000, 1'b0);
    push_item(16'd0,     1'b0);
    push_item(16'hFFFF,  1'b0);
    push_item(16'd12345, 1'b0);
    push_item(16'hFFFF,  1'b0);
    push_item(16'd0,     1'b1);
    drain();
    // k of zero, then a one-price sequence
    write_k(5'd0);
    push_item(16'd0,    1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(16'd0,    1'b0);
    push_item(16'hFFFF, 1'b1);
    push_item(16'hFFFF, 1'b1);
    drain();
    // every cell in use
    write_k(5'd16);
    for (int i = 0; i < 8; i++) push_item((i % 2) ? 16'hFFFF : 16'd0, i == 7);
    drain();
    // count above the cell chain clamps to the last cell
    write_k(5'd31);
    push_item(16'hFFFF, 1'b0);
    push_item(16'd0,    1'b0);
    push_item(16'hFFFF, 1'b1);
    drain();

    // Sequences run across phases, so k also changes mid-sequence
    for (int p = 0; p < PHASES; p++) begin
      k_next = (p < 6) ? k_fixed[p] : kmp_cfg_t'($urandom_range(31));
      write_k(k_next);
      src_idle_pct = (p == 4) ? 0 : 25;
      snk_idle_pct = (p == 4) ? 0 : 25;
      repeat (RAND_ITEMS / PHASES) begin
        price_q.push_back(make_item());
        n_queued++;
        if (price_q[$].last) n_seq_ends++;
      end
      drain();
    end

    repeat (2 * CELLS) @(posedge clk_i);
    $display("Ran %0d prices in %0d closed sequences, %0d results checked, %0d mismatches.",
             n_accepted, n_seq_ends, n_results, n_mismatch);
    $display("Transaction limits visited (bit per k): %b", k_seen);
    if (n_mismatch == 0 && profit_q.size() == 0) begin
      $display("k_transaction_max_profit_dp: match");
    end else begin
      $display("k_transaction_max_profit_dp: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", profit_q.size());
    $display("k_transaction_max_profit_dp: mismatch");
    $finish;
  end

endmodule
